// ===== src/dtbp_pkg.sv =====
// shared types and constants for the device tree blob token parser
`default_nettype none

package dtbp_pkg;

  localparam logic [31:0] FDT_MAGIC      = 32'hd00dfeed;
  localparam logic [31:0] HDR_BYTES      = 32'd40;
  localparam logic [31:0] TOKEN_LAST     = 32'd3;
  localparam logic [31:0] PROP_HDR_LAST  = 32'd7;
  localparam logic [31:0] PROP_LEN_LAST  = 32'd3;

  localparam logic [2:0] EV_BEGIN  = 3'd0;
  localparam logic [2:0] EV_PROP   = 3'd1;
  localparam logic [2:0] EV_DONE   = 3'd2;
  localparam logic [2:0] EV_FORMAT = 3'd3;
  localparam logic [2:0] EV_HEADER = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] name_offset;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

`default_nettype wire

// ===== src/dtbp_walker.sv =====
// parse state and per-byte header and token walk
`default_nettype none

module dtbp_walker
  import dtbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  in_item_t  item_i,
  output step_res_t res_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_TOKEN    = 3'd2;
  localparam logic [2:0] PH_NAME     = 3'd3;
  localparam logic [2:0] PH_PROP     = 3'd4;
  localparam logic [2:0] PH_SKIP     = 3'd5;
  localparam logic [2:0] PH_FINISHED = 3'd6;

  localparam logic [31:0] TK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TK_END_NODE   = 32'd2;
  localparam logic [31:0] TK_PROP       = 32'd3;
  localparam logic [31:0] TK_NOP        = 32'd4;
  localparam logic [31:0] TK_END        = 32'd9;

  logic [2:0]  phase_q, phase_d, phase_c;
  logic [31:0] pos_q, pos_d, pos_c;
  logic [31:0] wa_q, wa_d, wa_c;
  logic [31:0] sstart_q, sstart_d, sstart_c;
  logic [31:0] strs_q, strs_d, strs_c;
  logic [32:0] send_q, send_d, send_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [31:0] plen_q, plen_d, plen_c;

  logic        active;
  logic [31:0] nxt;
  logic [31:0] wa_n;
  logic [1:0]  end_lo;
  logic [32:0] gap;
  logic        take_gap;

  // a first byte restarts from cleared state in the same step
  assign phase_c  = item_i.first ? PH_HEADER : phase_q;
  assign pos_c    = item_i.first ? '0 : pos_q;
  assign wa_c     = item_i.first ? '0 : wa_q;
  assign sstart_c = item_i.first ? '0 : sstart_q;
  assign strs_c   = item_i.first ? '0 : strs_q;
  assign send_c   = item_i.first ? '0 : send_q;
  assign skip_c   = item_i.first ? '0 : skip_q;
  assign plen_c   = item_i.first ? '0 : plen_q;

  assign active = (phase_c != PH_IDLE) && (phase_c < PH_FINISHED);
  assign nxt    = pos_c + 32'd1;
  assign wa_n   = {wa_c[23:0], item_i.data_byte};
  assign end_lo = nxt[1:0] + plen_c[1:0];

  always_comb begin
    phase_d  = phase_c;
    pos_d    = pos_c;
    wa_d     = wa_c;
    sstart_d = sstart_c;
    strs_d   = strs_c;
    send_d   = send_c;
    skip_d   = skip_c;
    plen_d   = plen_c;
    gap      = '0;
    take_gap = 1'b0;
    res_o    = '0;
    if (active) begin
      pos_d = nxt;
      wa_d  = wa_n;
      case (phase_c)
        PH_HEADER: begin
          if (pos_c == 32'd3 && wa_n != FDT_MAGIC) begin
            phase_d                = PH_FINISHED;
            res_o.emit             = 1'b1;
            res_o.item.event_kind  = EV_HEADER;
          end else if (pos_c == 32'd11) begin
            sstart_d = wa_n;
          end else if (pos_c == 32'd15) begin
            strs_d = wa_n;
          end else if (pos_c == 32'd39) begin
            if (sstart_c < HDR_BYTES) begin
              phase_d               = PH_FINISHED;
              res_o.emit            = 1'b1;
              res_o.item.event_kind = EV_HEADER;
            end else begin
              send_d   = {1'b0, sstart_c} + {1'b0, wa_n};
              gap      = {1'b0, sstart_c - HDR_BYTES};
              take_gap = 1'b1;
            end
          end
        end
        PH_TOKEN: begin
          if (skip_c == '0 && {1'b0, pos_c} >= send_c) begin
            phase_d               = PH_FINISHED;
            res_o.emit            = 1'b1;
            res_o.item.event_kind = EV_DONE;
          end else if (skip_c < TOKEN_LAST) begin
            skip_d = skip_c + 32'd1;
          end else begin
            skip_d = '0;
            case (wa_n)
              TK_BEGIN_NODE: begin
                phase_d                = PH_NAME;
                res_o.emit             = 1'b1;
                res_o.item.event_kind  = EV_BEGIN;
                res_o.item.name_offset = nxt;
              end
              TK_END_NODE, TK_NOP: ;
              TK_PROP: phase_d = PH_PROP;
              TK_END: begin
                phase_d               = PH_FINISHED;
                res_o.emit            = 1'b1;
                res_o.item.event_kind = EV_DONE;
              end
              default: begin
                phase_d               = PH_FINISHED;
                res_o.emit            = 1'b1;
                res_o.item.event_kind = EV_FORMAT;
              end
            endcase
          end
        end
        PH_NAME: begin
          if (item_i.data_byte == 8'd0) begin
            gap      = {31'd0, 2'd0 - nxt[1:0]};
            take_gap = 1'b1;
          end
        end
        PH_PROP: begin
          if (skip_c == PROP_LEN_LAST) begin
            plen_d = wa_n;
          end
          if (skip_c < PROP_HDR_LAST) begin
            skip_d = skip_c + 32'd1;
          end else begin
            res_o.emit             = 1'b1;
            res_o.item.event_kind  = EV_PROP;
            res_o.item.name_offset = strs_c + wa_n;
            res_o.item.data_offset = nxt;
            res_o.item.data_length = plen_c;
            // value length plus padding up to the next aligned offset
            gap      = {1'b0, plen_c} + {31'd0, 2'd0 - end_lo};
            take_gap = 1'b1;
          end
        end
        PH_SKIP: begin
          if (skip_c <= 32'd1) begin
            phase_d = PH_TOKEN;
            skip_d  = '0;
          end else begin
            skip_d = skip_c - 32'd1;
          end
        end
        default: ;
      endcase
      if (take_gap) begin
        if (gap == '0) begin
          phase_d = PH_TOKEN;
          skip_d  = '0;
        end else begin
          phase_d = PH_SKIP;
          // saturate an oversized skip
          skip_d  = gap[32] ? '1 : gap[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      wa_q     <= '0;
      sstart_q <= '0;
      strs_q   <= '0;
      send_q   <= '0;
      skip_q   <= '0;
      plen_q   <= '0;
    end else if (go_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      wa_q     <= wa_d;
      sstart_q <= sstart_d;
      strs_q   <= strs_d;
      send_q   <= send_d;
      skip_q   <= skip_d;
      plen_q   <= plen_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_FINISHED)
    else $error("walker phase out of range");

  a_token_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TOKEN |-> skip_q <= TOKEN_LAST)
    else $error("token byte count out of range");

  a_prop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PROP |-> skip_q <= PROP_HDR_LAST)
    else $error("property header byte count out of range");

endmodule

`default_nettype wire

// ===== src/device_tree_blob_token_parser_unit.sv =====
// top level: input register, blob walker and result register
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------
//  in      | in_valid_i  | in_stall_o  | in_item_i  (data_byte, first)
//  out     | out_valid_o | out_stall_i | out_item_o (event fields)
//
// one blob byte per cycle sustained while no stalled result holds the input side;
// the walker steps each byte from the input register and its result is offered
// from the result register, where it is held until it transfers
// the rate is set by the registered state update of the walker
// reset is asynchronous active low and clears all parse state to idle
// a stalled result only holds the input side when the next byte has a result
`default_nettype none

module device_tree_blob_token_parser_unit
  import dtbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  in_item_t  in_q;
  logic      iv_q;
  out_item_t out_q;
  logic      ov_q;

  step_res_t res;
  logic      out_free;
  logic      go;
  logic      in_take;

  assign out_free   = !ov_q || !out_stall_i;
  assign go         = iv_q && (!res.emit || out_free);
  assign in_stall_o = iv_q && !go;
  assign in_take    = in_valid_i && !in_stall_o;

  dtbp_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (in_take) begin
        iv_q <= 1'b1;
      end else if (go) begin
        iv_q <= 1'b0;
      end
      if (go && res.emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (go && res.emit) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  // input side holds only behind a waiting result transfer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (iv_q && ov_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && res.emit) |-> out_free)
    else $error("result register overwritten");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/sv/tb_device_tree_blob_token_parser_unit.sv =====
// testbench for the device tree blob token parser: blob stimulus, event prediction and checks
`timescale 1ns / 1ps

module tb_device_tree_blob_token_parser_unit;
  import dtbp_pkg::*;

  localparam logic [31:0] BLOB_MAGIC      = 32'hd00dfeed;
  localparam logic [31:0] HEADER_LEN      = 32'd40;
  localparam logic [31:0] TOKEN_BYTES     = 32'd4;
  localparam logic [31:0] PROP_HEAD_BYTES = 32'd8;
  localparam logic [31:0] PROP_LEN_BYTE   = 32'd3;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [2:0] {
    WALK_IDLE, WALK_HEADER, WALK_TOKEN, WALK_NAME, WALK_PROP, WALK_SKIP, WALK_DONE
  } walk_phase_e;

  typedef enum int {
    BLOB_GOOD, BLOB_SHORT, BLOB_BAD_TOKEN, BLOB_HUGE_PROP,
    BLOB_BAD_MAGIC, BLOB_LOW_OFFSET, BLOB_FAR_STRUCT, BLOB_CUT
  } blob_flavor_e;

  // walks the blob alongside the block and keeps the events it should report
  class dt_event_board;
    walk_phase_e phase;
    logic [31:0] position;
    logic [31:0] shreg;
    logic [31:0] struct_base;
    logic [31:0] strings_base;
    logic [32:0] struct_limit;
    logic [31:0] count;
    logic [31:0] prop_len;
    out_item_t   events_due[$];
    int unsigned errors;
    int unsigned parsed;
    int unsigned predicted;
    int unsigned checked;
    int unsigned kind_seen[5];

    function new();
      phase = WALK_IDLE;
      position = '0;
      shreg = '0;
      struct_base = '0;
      strings_base = '0;
      struct_limit = '0;
      count = '0;
      prop_len = '0;
      errors = 0;
      parsed = 0;
      predicted = 0;
      checked = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void push_event(logic [2:0] kind, logic [31:0] nm, logic [31:0] dofs,
                             logic [31:0] dlen);
      out_item_t ev;
      ev.event_kind  = kind;
      ev.name_offset = nm;
      ev.data_offset = dofs;
      ev.data_length = dlen;
      events_due.push_back(ev);
      predicted++;
    endfunction

    function void finish_with(logic [2:0] kind);
      phase = WALK_DONE;
      push_event(kind, '0, '0, '0);
    endfunction

    function void gap_to_token(logic [63:0] gap);
      if (gap == 64'd0) begin
        phase = WALK_TOKEN;
        count = '0;
      end else begin
        phase = WALK_SKIP;
        count = (gap > 64'hffff_ffff) ? 32'hffff_ffff : gap[31:0];
      end
    endfunction

    function void note_byte(in_item_t it);
      logic [31:0] pos;
      logic [31:0] nxt;
      logic [63:0] fin;
      if (it.first) begin
        phase = WALK_HEADER;
        position = '0;
        shreg = '0;
        struct_base = '0;
        strings_base = '0;
        struct_limit = '0;
        count = '0;
        prop_len = '0;
      end
      if (phase == WALK_IDLE || phase == WALK_DONE) return;
      parsed++;
      pos = position;
      nxt = pos + 32'd1;
      shreg = {shreg[23:0], it.data_byte};
      case (phase)
        WALK_HEADER: begin
          if (pos == 32'd3 && shreg != BLOB_MAGIC) begin
            finish_with(EV_HEADER);
          end else if (pos == 32'd11) begin
            struct_base = shreg;
          end else if (pos == 32'd15) begin
            strings_base = shreg;
          end else if (pos == HEADER_LEN - 32'd1) begin
            if (struct_base < HEADER_LEN) begin
              finish_with(EV_HEADER);
            end else begin
              struct_limit = {1'b0, struct_base} + {1'b0, shreg};
              gap_to_token({32'd0, struct_base - HEADER_LEN});
            end
          end
        end
        WALK_TOKEN: begin
          // end of the structure block only counts where a new token would start
          if (count == '0 && {1'b0, pos} >= struct_limit) begin
            finish_with(EV_DONE);
          end else if (count < TOKEN_BYTES - 32'd1) begin
            count++;
          end else begin
            count = '0;
            case (shreg)
              TOK_BEGIN_NODE: begin
                phase = WALK_NAME;
                push_event(EV_BEGIN, nxt, '0, '0);
              end
              TOK_END_NODE, TOK_NOP: begin
              end
              TOK_PROP: begin
                phase = WALK_PROP;
              end
              TOK_END: begin
                finish_with(EV_DONE);
              end
              default: begin
                finish_with(EV_FORMAT);
              end
            endcase
          end
        end
        WALK_NAME: begin
          if (it.data_byte == 8'd0) gap_to_token({32'd0, (32'd4 - (nxt & 32'd3)) & 32'd3});
        end
        WALK_PROP: begin
          if (count == PROP_LEN_BYTE) prop_len = shreg;
          if (count < PROP_HEAD_BYTES - 32'd1) begin
            count++;
          end else begin
            fin = {32'd0, nxt} + {32'd0, prop_len};
            push_event(EV_PROP, strings_base + shreg, nxt, prop_len);
            gap_to_token(((fin + 64'd3) & ~64'd3) - {32'd0, nxt});
          end
        end
        WALK_SKIP: begin
          if (count <= 32'd1) begin
            phase = WALK_TOKEN;
            count = '0;
          end else begin
            count--;
          end
        end
        default: begin
        end
      endcase
      position = nxt;
    endfunction

    function void field_check(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, got kind %0d name %0h data %0h len %0h",
                 $time, got.event_kind, got.name_offset, got.data_offset, got.data_length);
        return;
      end
      want = events_due.pop_front();
      checked++;
      kind_seen[want.event_kind]++;
      field_check("event_kind", {29'd0, want.event_kind}, {29'd0, got.event_kind});
      field_check("name_offset", want.name_offset, got.name_offset);
      field_check("data_offset", want.data_offset, got.data_offset);
      field_check("data_length", want.data_length, got.data_length);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  dt_event_board board;
  logic [7:0]    blob_q[$];
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  bit            hold_req = 1'b0;
  int unsigned   blob_count = 0;

  device_tree_blob_token_parser_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void put_word(logic [31:0] w);
    blob_q.push_back(w[31:24]);
    blob_q.push_back(w[23:16]);
    blob_q.push_back(w[15:8]);
    blob_q.push_back(w[7:0]);
  endfunction

  // padding follows blob offsets, not offsets within the structure block
  function automatic void pad_align();
    while (blob_q.size() % 4 != 0) blob_q.push_back($urandom_range(0, 255));
  endfunction

  function automatic void make_blob(blob_flavor_e flav);
    logic [31:0] sofs;
    logic [31:0] len;
    logic [31:0] tok;
    int          body;
    int          cut;
    blob_q.delete();
    if (flav == BLOB_BAD_MAGIC) begin
      put_word(($urandom_range(0, 1) == 0) ? (BLOB_MAGIC ^ (32'd1 << $urandom_range(0, 31)))
                                           : $urandom);
    end else begin
      put_word(BLOB_MAGIC);
    end
    put_word($urandom);
    if (flav == BLOB_LOW_OFFSET) begin
      sofs = $urandom_range(0, 39);
    end else if (flav == BLOB_FAR_STRUCT) begin
      sofs = $urandom | 32'h0000_1000;
    end else if ($urandom_range(0, 3) == 0) begin
      sofs = HEADER_LEN + $urandom_range(0, 11);
    end else begin
      sofs = HEADER_LEN + 4 * $urandom_range(0, 3);
    end
    put_word(sofs);
    put_word($urandom);
    repeat (6) put_word($urandom);
    if (flav == BLOB_BAD_MAGIC) begin
      cut = $urandom_range(4, 10);
      while (blob_q.size() > cut) void'(blob_q.pop_back());
      return;
    end
    if (flav == BLOB_LOW_OFFSET || flav == BLOB_FAR_STRUCT) begin
      repeat (8) blob_q.push_back($urandom_range(0, 255));
      return;
    end
    while (blob_q.size() < sofs) blob_q.push_back($urandom_range(0, 255));
    body = blob_q.size();
    repeat ($urandom_range(2, 12)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          put_word(TOK_BEGIN_NODE);
          repeat ($urandom_range(0, 6)) blob_q.push_back($urandom_range(1, 255));
          blob_q.push_back(8'd0);
          pad_align();
        end
        3, 4, 5, 6: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
          put_word(TOK_PROP);
          put_word(len);
          put_word(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 64));
          repeat (len) blob_q.push_back($urandom_range(0, 255));
          pad_align();
        end
        7: put_word(TOK_END_NODE);
        default: put_word(TOK_NOP);
      endcase
    end
    case (flav)
      BLOB_BAD_TOKEN: begin
        case ($urandom_range(0, 2))
          0: tok = $urandom_range(5, 8);
          1: tok = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd10;
          default: tok = $urandom;
        endcase
        if (tok == TOK_BEGIN_NODE || tok == TOK_END_NODE || tok == TOK_PROP ||
            tok == TOK_NOP || tok == TOK_END) tok = 32'd0;
        put_word(tok);
      end
      BLOB_HUGE_PROP: begin
        // value length so large that the padded skip can saturate
        put_word(TOK_PROP);
        put_word(32'hffff_ffff - $urandom_range(0, 3));
        put_word($urandom);
        repeat (12) blob_q.push_back($urandom_range(0, 255));
      end
      default: put_word(TOK_END);
    endcase
    len = blob_q.size() - body;
    if (flav == BLOB_SHORT) begin
      len = $urandom_range(0, len);
    end else begin
      case ($urandom_range(0, 3))
        0: len = 32'hffff_ffff;
        1: len = len + $urandom_range(1, 16);
        default: begin
        end
      endcase
    end
    blob_q[36] = len[31:24];
    blob_q[37] = len[23:16];
    blob_q[38] = len[15:8];
    blob_q[39] = len[7:0];
    if (flav == BLOB_CUT) begin
      cut = $urandom_range(41, blob_q.size() - 1);
      while (blob_q.size() > cut) void'(blob_q.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f);
    in_item_t it;
    it.data_byte = b;
    it.first     = f;
    // the last part of the run goes without idling on either side
    if (board.parsed >= 600) begin
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
    end
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    board.note_byte(it);
  endtask

  task automatic run_blob(input blob_flavor_e flav);
    make_blob(flav);
    foreach (blob_q[i]) send_byte(blob_q[i], i == 0);
    // trailing bytes that land after the final event are dropped
    repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255), 1'b0);
    blob_count++;
  endtask

  // receiver: checks each transfer, stalls in bursts, holds off once for a long time
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) board.check_event(out_item);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned r;
    blob_flavor_e flav;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes before any header marker are dropped
    repeat (3) send_byte($urandom_range(0, 255), 1'b0);
    for (int k = 0; k <= BLOB_CUT; k++) begin
      // long receiver hold while the sender keeps streaming blobs
      if (k == 2) hold_req = 1'b1;
      run_blob(blob_flavor_e'(k));
    end

    while (board.parsed < 700 || board.predicted < 60) begin
      if (board.parsed >= 600) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      flav = (r < 58) ? BLOB_GOOD :
             (r < 68) ? BLOB_SHORT :
             (r < 76) ? BLOB_BAD_TOKEN :
             (r < 81) ? BLOB_HUGE_PROP :
             (r < 87) ? BLOB_BAD_MAGIC :
             (r < 93) ? BLOB_LOW_OFFSET :
             (r < 96) ? BLOB_FAR_STRUCT : BLOB_CUT;
      run_blob(flav);
    end
    in_valid <= 1'b0;

    while (board.events_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d blobs, %0d parsed bytes and %0d checked events",
             blob_count, board.parsed, board.checked);
    $display("events by kind: begin %0d, property %0d, done %0d, format err %0d, header err %0d",
             board.kind_seen[EV_BEGIN], board.kind_seen[EV_PROP], board.kind_seen[EV_DONE],
             board.kind_seen[EV_FORMAT], board.kind_seen[EV_HEADER]);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
